/* rtl/rec_pkg.sv */
// ----------------------------------------------------------------------------
// rec_pkg: shared types and constants for the exact rational comparator
// Holds the value width, result codes, controller states and the command
// and status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rec_pkg;

  // Width of one input field on the bus
  localparam int unsigned FieldWidth = 64;
  // Width of the values actually compared (8..64)
  localparam int unsigned ValueWidth = 64;
  // Divider step counter holds 0..ValueWidth
  localparam int unsigned CountWidth = $clog2(ValueWidth + 1);

  // Result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  // Order codes, two's complement
  localparam logic [1:0] ORDER_LESS    = 2'b11;
  localparam logic [1:0] ORDER_EQUAL   = 2'b00;
  localparam logic [1:0] ORDER_GREATER = 2'b01;

  typedef logic [ValueWidth-1:0] value_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_LEFT,
    S_DIV_RIGHT,
    S_COMPARE,
    S_OUT
  } rec_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture a new request
    logic div_start;  // launch a division
    logic div_right;  // select the right fraction for the division
    logic save_left;  // keep the left quotient and remainder
    logic compare;    // compare one level, then swap or finish
    logic finish;     // write the sign-only or invalid result
  } rec_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic early;      // invalid or signs differ: no expansion needed
    logic div_done;   // divider finished
    logic final_lvl;  // this level decides the order
  } rec_sts_t;

  // Flip the sense of an order code
  function automatic logic [1:0] negate_order(logic [1:0] ord);
    logic [1:0] res;
    res = ORDER_EQUAL;
    case (ord)
      ORDER_LESS:    res = ORDER_GREATER;
      ORDER_GREATER: res = ORDER_LESS;
      default:       res = ORDER_EQUAL;
    endcase
    return res;
  endfunction

  // Magnitude of a two's complement value; the most negative one maps to 2^(W-1)
  function automatic value_t magnitude(value_t v);
    return v[ValueWidth-1] ? value_t'(~v + value_t'(1)) : v;
  endfunction

endpackage

/* rtl/rec_div.sv */
// ----------------------------------------------------------------------------
// rec_div: radix-2 restoring divider
// One quotient bit per cycle; quotient and remainder hold after done until
// the next start.
// ----------------------------------------------------------------------------
module rec_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  rec_pkg::value_t dividend_i,
  input  rec_pkg::value_t divisor_i,
  output logic            done_o,
  output rec_pkg::value_t quotient_o,
  output rec_pkg::value_t remainder_o
);
  import rec_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  value_t                quo_q, quo_d;
  value_t                rem_q, rem_d;
  value_t                dvs_q, dvs_d;
  logic [ValueWidth:0]   shifted;
  logic [ValueWidth:0]   trial;

  // Shift in the next dividend bit and try a subtraction
  assign shifted = {rem_q, quo_q[ValueWidth-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CountWidth'(ValueWidth);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!trial[ValueWidth]) begin
        rem_d = trial[ValueWidth-1:0];
        quo_d = {quo_q[ValueWidth-2:0], 1'b1};
      end else begin
        rem_d = shifted[ValueWidth-1:0];
        quo_d = {quo_q[ValueWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q - CountWidth'(1);
      if (cnt_q == CountWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and result registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

/* rtl/rec_dpath.sv */
// ----------------------------------------------------------------------------
// rec_dpath: operand registers, level compare and result register
// Holds both fractions, feeds the shared divider one side at a time and
// decides or swaps at each continued-fraction level.
// ----------------------------------------------------------------------------
module rec_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rec_pkg::rec_cmd_t                 cmd_i,
  output rec_pkg::rec_sts_t                 sts_o,
  input  logic [rec_pkg::FieldWidth-1:0]    left_numerator_i,
  input  logic [rec_pkg::FieldWidth-1:0]    left_denominator_i,
  input  logic [rec_pkg::FieldWidth-1:0]    right_numerator_i,
  input  logic [rec_pkg::FieldWidth-1:0]    right_denominator_i,
  output logic                              status_o,
  output logic [1:0]                        order_o
);
  import rec_pkg::*;

  value_t     ln_q, ld_q, rn_q, rd_q;
  value_t     lq_q, lr_q;
  logic       invalid_q, lneg_q, rneg_q, flip_q;
  logic       status_q;
  logic [1:0] order_q;

  value_t     in_ln, in_ld, in_rn, in_rd;
  value_t     div_dvd, div_dvs, div_quo, div_rem;
  logic       div_done;
  logic [1:0] lvl_order;
  logic       lvl_final;

  // Keep the low value bits of each field
  assign in_ln = left_numerator_i[ValueWidth-1:0];
  assign in_ld = left_denominator_i[ValueWidth-1:0];
  assign in_rn = right_numerator_i[ValueWidth-1:0];
  assign in_rd = right_denominator_i[ValueWidth-1:0];

  // Operand select for the shared divider
  assign div_dvd = cmd_i.div_right ? rn_q : ln_q;
  assign div_dvs = cmd_i.div_right ? rd_q : ld_q;

  rec_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dvs),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Decide one level: quotients first, then zero remainders
  always_comb begin
    lvl_final = 1'b1;
    lvl_order = ORDER_EQUAL;
    if (lq_q != div_quo) begin
      lvl_order = (lq_q < div_quo) ? ORDER_LESS : ORDER_GREATER;
    end else if (lr_q == '0 && div_rem == '0) begin
      lvl_order = ORDER_EQUAL;
    end else if (lr_q == '0) begin
      lvl_order = ORDER_LESS;
    end else if (div_rem == '0) begin
      lvl_order = ORDER_GREATER;
    end else begin
      lvl_final = 1'b0;
    end
    if (flip_q ^ lneg_q) begin
      lvl_order = negate_order(lvl_order);
    end
  end

  // Flags captured with each request; the level flip toggles at each undecided level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invalid_q <= 1'b0;
      lneg_q    <= 1'b0;
      rneg_q    <= 1'b0;
      flip_q    <= 1'b0;
    end else if (cmd_i.load) begin
      invalid_q <= (in_ld == '0) || in_ld[ValueWidth-1] ||
                   (in_rd == '0) || in_rd[ValueWidth-1];
      lneg_q    <= in_ln[ValueWidth-1];
      rneg_q    <= in_rn[ValueWidth-1];
      flip_q    <= 1'b0;
    end else if (cmd_i.compare && !lvl_final) begin
      flip_q    <= !flip_q;
    end
  end

  // Operand registers: load, or invert both fractions for the next level
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ln_q <= magnitude(in_ln);
      ld_q <= in_ld;
      rn_q <= magnitude(in_rn);
      rd_q <= in_rd;
    end else if (cmd_i.compare && !lvl_final) begin
      ln_q <= ld_q;
      ld_q <= lr_q;
      rn_q <= rd_q;
      rd_q <= div_rem;
    end
    if (cmd_i.save_left) begin
      lq_q <= div_quo;
      lr_q <= div_rem;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= STATUS_OK;
      order_q  <= ORDER_EQUAL;
    end else if (cmd_i.finish) begin
      if (invalid_q) begin
        status_q <= STATUS_INVALID;
        order_q  <= ORDER_EQUAL;
      end else begin
        status_q <= STATUS_OK;
        order_q  <= lneg_q ? ORDER_LESS : ORDER_GREATER;
      end
    end else if (cmd_i.compare && lvl_final) begin
      status_q <= STATUS_OK;
      order_q  <= lvl_order;
    end
  end

  assign sts_o.early     = invalid_q || (lneg_q != rneg_q);
  assign sts_o.div_done  = div_done;
  assign sts_o.final_lvl = lvl_final;
  assign status_o        = status_q;
  assign order_o         = order_q;

endmodule

/* rtl/rec_ctrl.sv */
// ----------------------------------------------------------------------------
// rec_ctrl: sequencer for the comparator
// Accepts a request, runs left and right divisions per level and presents
// the result until it is taken.
// ----------------------------------------------------------------------------
module rec_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rec_pkg::rec_cmd_t cmd_o,
  input  rec_pkg::rec_sts_t sts_i
);
  import rec_pkg::*;

  rec_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        state_d = sts_i.early ? S_OUT : S_DIV_LEFT;
      end
      S_DIV_LEFT: begin
        if (sts_i.div_done) state_d = S_DIV_RIGHT;
      end
      S_DIV_RIGHT: begin
        if (sts_i.div_done) state_d = S_COMPARE;
      end
      S_COMPARE: begin
        state_d = sts_i.final_lvl ? S_OUT : S_CHECK;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Commands and handshake
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_CHECK: begin
        cmd_o.finish    = sts_i.early;
        cmd_o.div_start = !sts_i.early;
      end
      S_DIV_LEFT: begin
        cmd_o.save_left = sts_i.div_done;
        cmd_o.div_start = sts_i.div_done;
        cmd_o.div_right = 1'b1;
      end
      S_COMPARE: begin
        cmd_o.compare = 1'b1;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/rational_exact_compare.sv */
// ----------------------------------------------------------------------------
// rational_exact_compare: exact order of two signed fractions
// A request with an invalid denominator or differing signs finishes without
// expansion; any other runs a left and a right division at each level.
// One request at a time; the shared one-bit-per-cycle divider runs twice per
// continued-fraction level and sets how long a request takes.
// Reset: asynchronous, active low; returns to idle with no result pending.
// ----------------------------------------------------------------------------
module rational_exact_compare (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // left_numerator, left_denominator, right_numerator, right_denominator
  input  logic [255:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, order, zero fill
  output logic [7:0]   m_axis_tdata
);
  import rec_pkg::*;

  rec_cmd_t   cmd;
  rec_sts_t   sts;
  logic       status;
  logic [1:0] order;

  rec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rec_dpath u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .left_numerator_i    (s_axis_tdata[FieldWidth-1:0]),
    .left_denominator_i  (s_axis_tdata[2*FieldWidth-1:FieldWidth]),
    .right_numerator_i   (s_axis_tdata[3*FieldWidth-1:2*FieldWidth]),
    .right_denominator_i (s_axis_tdata[4*FieldWidth-1:3*FieldWidth]),
    .status_o            (status),
    .order_o             (order)
  );

  // Pack the result
  assign m_axis_tdata = {5'b0, order, status};

  // Invalid requests report an equal order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0] == STATUS_INVALID) |->
      (m_axis_tdata[2:1] == ORDER_EQUAL))
    else $error("invalid result carries a nonzero order");

  // The unused order code never appears
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:1] != 2'b10))
    else $error("order code out of range");

  // One request in flight: no accept while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(m_axis_tvalid && s_axis_tready))
    else $error("input ready while result pending");

  // An accepted request closes the input for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after accept");

endmodule
